@@ hdl/tccs_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the text console.
package tccs_pkg;

    localparam int DEF_COLS = 80;
    localparam int DEF_ROWS = 25;

    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int POS_W   = 11;
    localparam int DATA_W  = 16;
    localparam int COLOR_W = 4;

    localparam logic [CHAR_W-1:0] CH_NEWLINE       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_FIRST_PRINT   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST_PRINT    = 8'h7F;

    localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 4'd2;
    localparam logic [COLOR_W-1:0] BACK_COLOR_RST = 4'd0;

    // register select, taken from paddr[2]
    localparam logic REG_TEXT_COLOR = 1'b0;
    localparam logic REG_BACK_COLOR = 1'b1;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic take;      // latch the incoming request
        logic sweep;     // one step of the store sweep (scroll or clear)
        logic zero;      // sweep writes zeros everywhere (power-up clear)
        logic rd_cell;   // read the requested cell
        logic wr_char;   // write the character cell
        logic finish;    // update cursor and load the result register
    } tccs_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic is_read;
        logic is_print;
        logic need_scroll;
        logic out_full;
    } tccs_stat_t;

endpackage

@@ hdl/text_console_cursor_scroll_top.sv @@
// Top level of the text console: stream ports, color registers, controller and datapath.
//
//  channel   dir  handshake               payload
//  s_*       in   s_tvalid / s_tready     s_tdata: char_code, cell_index; s_tuser: func
//  m_*       out  m_tvalid / m_tready     m_tdata: cursor_pos, cell_data, scrolled
//  apb       in   psel, penable, pready   text_color at 0x0, back_color at 0x4
//
// Read requests and puts without scroll pass through the dispatch and result states;
// m_tvalid rises and s_tready returns in the same cycle, so no new request is taken
// until the last result is loaded. A put that scrolls walks the whole cell store,
// moving each row up by one and zeroing the last row. After reset the store is
// cleared one cell per cycle with s_tready low. The result register lets the
// next request be accepted while a result waits; a full result register
// holds the controller in its final state.
module text_console_cursor_scroll_top
    import tccs_pkg::*;
#(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [10:0] cursor_pos, [26:11] cell_data, [27] scrolled
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tccs_cmd_t  cmd;
    tccs_stat_t stat;

    logic [COLOR_W-1:0] text_color_reg, text_color_next;
    logic [COLOR_W-1:0] back_color_reg, back_color_next;
    logic               cfg_wr;

    logic [POS_W-1:0]  out_cursor;
    logic [DATA_W-1:0] out_data;
    logic              out_scrolled;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        text_color_next = text_color_reg;
        back_color_next = back_color_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_TEXT_COLOR: text_color_next = pwdata[COLOR_W-1:0];
                REG_BACK_COLOR: back_color_next = pwdata[COLOR_W-1:0];
                default:        text_color_next = text_color_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TEXT_COLOR: prdata = 32'(text_color_reg);
            REG_BACK_COLOR: prdata = 32'(back_color_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= TEXT_COLOR_RST;
            back_color_reg <= BACK_COLOR_RST;
        end
        else
        begin
            text_color_reg <= text_color_next;
            back_color_reg <= back_color_next;
        end
    end

    tccs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tccs_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_func      (s_tuser),
        .in_char      (s_tdata[7:0]),
        .in_idx       (s_tdata[18:8]),
        .text_color   (text_color_reg),
        .back_color   (back_color_reg),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_cursor   (out_cursor),
        .out_data     (out_data),
        .out_scrolled (out_scrolled)
    );

    assign m_tdata = {4'b0, out_scrolled, out_data, out_cursor};

endmodule

@@ hdl/tccs_ctrl.sv @@
// Controller state machine for the text console: clear, dispatch, scroll, write, result.
module tccs_ctrl
    import tccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  tccs_stat_t stat,
    output tccs_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR    = 6'b000001,
        ST_IDLE     = 6'b000010,
        ST_DISPATCH = 6'b000100,
        ST_SCROLL   = 6'b001000,
        ST_WRITE    = 6'b010000,
        ST_DONE     = 6'b100000
    } tccs_state_t;

    tccs_state_t state_reg;
    tccs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                cmd.zero  = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.is_read)
                begin
                    cmd.rd_cell = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (stat.need_scroll)
                begin
                    state_next = ST_SCROLL;
                end
                else if (stat.is_print)
                begin
                    cmd.wr_char = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = stat.is_print ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE:
            begin
                cmd.wr_char = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!stat.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/tccs_dp.sv @@
// Datapath for the text console: cell store, sweep counters, cursor and result register.
module tccs_dp
    import tccs_pkg::*;
#(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tccs_cmd_t          cmd,
    output tccs_stat_t         stat,
    input  logic               in_func,
    input  logic [CHAR_W-1:0]  in_char,
    input  logic [IDX_W-1:0]   in_idx,
    input  logic [COLOR_W-1:0] text_color,
    input  logic [COLOR_W-1:0] back_color,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [POS_W-1:0]   out_cursor,
    output logic [DATA_W-1:0]  out_data,
    output logic               out_scrolled
);

    localparam int CELLS    = ROWS * COLS;
    localparam int LAST_ROW = CELLS - COLS;
    localparam int AW       = $clog2(CELLS);
    localparam int CW       = $clog2(CELLS + 1);
    localparam int COLW     = $clog2(COLS);

    localparam logic [CW-1:0]   CELLS_C    = CW'(CELLS);
    localparam logic [CW-1:0]   LAST_ROW_C = CW'(LAST_ROW);
    localparam logic [CW-1:0]   LAST_CELL  = CW'(CELLS - 1);
    localparam logic [CW-1:0]   COLS_C     = CW'(COLS);
    localparam logic [COLW-1:0] COL_LAST   = COLW'(COLS - 1);
    localparam logic [31:0]     CELLS_32   = 32'(CELLS);

    logic [DATA_W-1:0] mem [CELLS];
    logic [DATA_W-1:0] mem_q_reg;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_wdata;

    // latched request
    logic              func_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              idx_ok_reg;

    logic [CW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic            pend_reg, pend_next;
    logic            sweep_zero;
    logic            sweep_rd;
    logic            sweep_we;

    logic [CW-1:0]   cursor_reg, cursor_next;
    logic [CW-1:0]   row_base_reg, row_base_next;
    logic [COLW-1:0] col_reg, col_next;

    logic            out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  out_cursor_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_scrolled_reg;

    logic is_nl;
    logic is_cr;
    logic is_print;
    logic at_end;
    logic on_last_row;
    logic need_scroll;
    logic [AW-1:0] char_addr;

    // request decode
    assign is_nl       = (func_reg == FUNC_PUT) && (char_reg == CH_NEWLINE);
    assign is_cr       = (func_reg == FUNC_PUT) && (char_reg == CH_RETURN);
    assign is_print    = (func_reg == FUNC_PUT) && (char_reg >= CH_FIRST_PRINT)
                         && (char_reg <= CH_LAST_PRINT);
    assign at_end      = (row_base_reg == CELLS_C);
    assign on_last_row = (row_base_reg == LAST_ROW_C);
    assign need_scroll = (is_print && at_end)
                         || (is_nl && (at_end || (on_last_row && (col_reg != '0))));

    assign stat.sweep_last  = (wr_ptr_reg == LAST_CELL);
    assign stat.is_read     = (func_reg == FUNC_READ);
    assign stat.is_print    = is_print;
    assign stat.need_scroll = need_scroll;
    assign stat.out_full    = out_valid_reg && !out_ready;

    // sweep: reads run ahead of writes through mem_q_reg, rows move up by COLS
    assign sweep_zero = cmd.zero || (wr_ptr_reg >= LAST_ROW_C);
    assign sweep_rd   = cmd.sweep && !cmd.zero && (rd_ptr_reg < CELLS_C);
    assign sweep_we   = cmd.sweep && (sweep_zero || pend_reg);

    // after a scroll the character lands at the start of the last row
    assign char_addr = need_scroll ? LAST_ROW_C[AW-1:0] : cursor_reg[AW-1:0];

    assign mem_we    = sweep_we || cmd.wr_char;
    assign mem_waddr = cmd.wr_char ? char_addr : wr_ptr_reg[AW-1:0];
    assign mem_wdata = cmd.wr_char ? {back_color, text_color, char_reg}
                                   : (sweep_zero ? '0 : mem_q_reg);
    assign mem_re    = sweep_rd || (cmd.rd_cell && idx_ok_reg);
    assign mem_raddr = cmd.rd_cell ? AW'(idx_reg) : rd_ptr_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            func_reg   <= in_func;
            char_reg   <= in_char;
            idx_reg    <= in_idx;
            idx_ok_reg <= (32'(in_idx) < CELLS_32);
        end
        if (cmd.finish)
        begin
            out_cursor_reg   <= POS_W'(cursor_next);
            out_data_reg     <= (stat.is_read && idx_ok_reg) ? mem_q_reg : '0;
            out_scrolled_reg <= need_scroll;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        pend_next   = pend_reg;
        if (cmd.sweep)
        begin
            pend_next = sweep_rd;
            if (sweep_we)
            begin
                wr_ptr_next = wr_ptr_reg + CW'(1);
            end
            if (sweep_rd)
            begin
                rd_ptr_next = rd_ptr_reg + CW'(1);
            end
            if (stat.sweep_last)
            begin
                wr_ptr_next = '0;
                rd_ptr_next = COLS_C;
                pend_next   = 1'b0;
            end
        end
    end

    // cursor is kept as row base plus column, so no modulo is needed
    always_comb
    begin
        cursor_next   = cursor_reg;
        row_base_next = row_base_reg;
        col_next      = col_reg;
        if (is_nl)
        begin
            col_next = '0;
            if (!need_scroll)
            begin
                row_base_next = row_base_reg + COLS_C;
            end
            cursor_next = row_base_next;
        end
        else if (is_cr)
        begin
            col_next    = '0;
            cursor_next = row_base_reg;
        end
        else if (is_print)
        begin
            if (need_scroll)
            begin
                row_base_next = LAST_ROW_C;
                col_next      = COLW'(1);
                cursor_next   = LAST_ROW_C + CW'(1);
            end
            else
            begin
                cursor_next = cursor_reg + CW'(1);
                if (col_reg == COL_LAST)
                begin
                    row_base_next = row_base_reg + COLS_C;
                    col_next      = '0;
                end
                else
                begin
                    col_next = col_reg + COLW'(1);
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= COLS_C;
            pend_reg      <= 1'b0;
            cursor_reg    <= '0;
            row_base_reg  <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cmd.finish)
            begin
                cursor_reg   <= cursor_next;
                row_base_reg <= row_base_next;
                col_reg      <= col_next;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_cursor   = out_cursor_reg;
    assign out_data     = out_data_reg;
    assign out_scrolled = out_scrolled_reg;

endmodule

@@ sim/tb_text_console_cursor_scroll_top.sv @@
// Self-checking testbench for the text console: stream requests, predicted screen, color phases.
module tb_text_console_cursor_scroll_top;
    import tccs_pkg::*;

    localparam int COLS  = DEF_COLS;
    localparam int ROWS  = DEF_ROWS;
    localparam int CELLS = COLS * ROWS;
    localparam int RANDOM_ITEMS = 1850;
    localparam int PHASES = 7;
    localparam int SETTLE_CYCLES = CELLS + 64;
    // every request scrolling, plus stalls, taken a few times over
    localparam int CYCLE_LIMIT = 16_000_000;

    typedef struct packed {
        logic              func;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } console_req_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [DATA_W-1:0] cell_data;
        logic              scrolled;
    } console_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [7:0] char_code, [18:8] cell_index, rest zero
    logic        s_tuser = 1'b0; // [0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [10:0] cursor_pos, [26:11] cell_data, [27] scrolled
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    text_console_cursor_scroll_top #(.COLS(COLS), .ROWS(ROWS)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow of the console state
    logic [DATA_W-1:0]  screen_model [CELLS] = '{default: '0};
    int unsigned        cursor_model = 0;
    logic [COLOR_W-1:0] fg_model = TEXT_COLOR_RST;
    logic [COLOR_W-1:0] bg_model = BACK_COLOR_RST;

    console_req_t    char_requests [$];
    console_result_t console_results_due [$];
    console_req_t    next_req;
    console_result_t oldest_result;
    int              queued_count = 0;
    int              accepted_count = 0;
    int              error_count = 0;
    int              cycle_count = 0;
    logic            steady;

    // long stretch with no idling on either side
    assign steady = (cycle_count >= 40000) && (cycle_count < 90000);

    initial begin
        forever #6 clk = ~clk;
    end

    task automatic report_error(input string msg);
        if (error_count < 60)
            $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic void shift_screen_up();
        int i;
        for (i = 0; i < CELLS - COLS; i++)
            screen_model[i] = screen_model[i + COLS];
        for (i = CELLS - COLS; i < CELLS; i++)
            screen_model[i] = '0;
    endfunction

    function automatic console_result_t console_apply(input logic func,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [IDX_W-1:0] idx);
        console_result_t res;
        res = '0;
        if (func == FUNC_READ) begin
            if (idx < CELLS)
                res.cell_data = screen_model[idx];
        end
        else if (ch == CH_NEWLINE || ch == CH_RETURN) begin
            if (ch == CH_NEWLINE) begin
                cursor_model += COLS;
                if (cursor_model > CELLS) begin
                    shift_screen_up();
                    res.scrolled = 1'b1;
                    cursor_model -= COLS;
                end
            end
            cursor_model -= cursor_model % COLS;
        end
        else if (ch >= CH_FIRST_PRINT && ch <= CH_LAST_PRINT) begin
            cursor_model += 1;
            if (cursor_model > CELLS) begin
                shift_screen_up();
                res.scrolled = 1'b1;
                cursor_model -= COLS;
            end
            if (cursor_model >= 1 && cursor_model - 1 < CELLS)
                screen_model[cursor_model - 1] = {bg_model, fg_model, ch};
        end
        res.cursor_pos = cursor_model[POS_W-1:0];
        return res;
    endfunction

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("text_console_cursor_scroll_top verification failed");
            $finish;
        end
    end

    // request driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                console_results_due.push_back(console_apply(s_tuser, s_tdata[7:0],
                                                            s_tdata[18:8]));
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (char_requests.size() != 0 && (steady || $urandom_range(0, 99) >= 9)) begin
                    next_req = char_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, next_req.cell_index, next_req.char_code};
                    s_tuser  <= next_req.func;
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (console_results_due.size() == 0) begin
                    report_error($sformatf("result %08h with no request outstanding", m_tdata));
                end
                else begin
                    oldest_result = console_results_due.pop_front();
                    if (m_tdata[10:0] !== oldest_result.cursor_pos)
                        report_error($sformatf("cursor_pos got %0d want %0d",
                                               m_tdata[10:0], oldest_result.cursor_pos));
                    if (m_tdata[26:11] !== oldest_result.cell_data)
                        report_error($sformatf("cell_data got %04h want %04h",
                                               m_tdata[26:11], oldest_result.cell_data));
                    if (m_tdata[27] !== oldest_result.scrolled)
                        report_error($sformatf("scrolled got %0b want %0b",
                                               m_tdata[27], oldest_result.scrolled));
                end
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    task automatic queue_req(input logic func, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx);
        char_requests.push_back('{func: func, char_code: ch, cell_index: idx});
        queued_count++;
    endtask

    task automatic wait_idle();
        while (!(accepted_count == queued_count && console_results_due.size() == 0))
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_color(input logic reg_sel, input logic [COLOR_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        // upper bits are junk; only the nibble is kept
        pwdata  <= ($urandom() & ~32'hF) | 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_TEXT_COLOR)
            fg_model = value;
        else
            bg_model = value;
    endtask

    initial begin
        int phase;
        int n;
        int pick;
        logic [COLOR_W-1:0] fg_set [PHASES];
        logic [COLOR_W-1:0] bg_set [PHASES];
        logic [CHAR_W-1:0] ch;

        fg_set = '{4'd15, 4'd0, 4'($urandom), 4'd15, 4'd0, 4'($urandom), TEXT_COLOR_RST};
        bg_set = '{4'd15, 4'd0, 4'($urandom), 4'd0, 4'd15, 4'($urandom), BACK_COLOR_RST};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: store edges, read past the end, both printable limits, ignored bytes
        queue_req(FUNC_READ, 8'hFF, 11'd0);
        queue_req(FUNC_READ, 8'h00, 11'(CELLS - 1));
        queue_req(FUNC_READ, 8'h41, 11'(CELLS));
        queue_req(FUNC_READ, 8'h00, 11'h7FF);
        queue_req(FUNC_PUT, CH_FIRST_PRINT, 11'h7FF);
        queue_req(FUNC_PUT, CH_LAST_PRINT, 11'd0);
        queue_req(FUNC_PUT, 8'h41, 11'h555);
        queue_req(FUNC_READ, 8'h00, 11'd0);
        queue_req(FUNC_READ, 8'h00, 11'd2);
        queue_req(FUNC_PUT, CH_RETURN, 11'd0);
        queue_req(FUNC_PUT, 8'h00, 11'd0);
        queue_req(FUNC_PUT, 8'h1F, 11'd0);
        queue_req(FUNC_PUT, 8'h80, 11'd0);
        queue_req(FUNC_PUT, 8'hFF, 11'd0);
        queue_req(FUNC_PUT, 8'h0B, 11'd0);
        queue_req(FUNC_PUT, 8'h42, 11'd0);
        queue_req(FUNC_PUT, CH_NEWLINE, 11'd0);
        // walk down to the last row; the newline from its start parks past the end
        for (n = 0; n < ROWS - 1; n++)
            queue_req(FUNC_PUT, CH_NEWLINE, 11'($urandom));
        queue_req(FUNC_PUT, 8'h5A, 11'd0);
        queue_req(FUNC_READ, 8'h00, 11'(CELLS - COLS));
        queue_req(FUNC_READ, 8'h00, 11'd0);
        queue_req(FUNC_PUT, CH_NEWLINE, 11'd0);
        queue_req(FUNC_PUT, 8'h71, 11'd0);
        wait_idle();

        for (phase = 0; phase < PHASES; phase++) begin
            write_color(REG_TEXT_COLOR, fg_set[phase]);
            write_color(REG_BACK_COLOR, bg_set[phase]);
            for (n = 0; n < RANDOM_ITEMS / PHASES + 1; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    queue_req(FUNC_READ, 8'($urandom),
                              ($urandom_range(0, 9) == 0) ? 11'($urandom)
                                                          : 11'($urandom_range(0, CELLS - 1)));
                end
                else if (pick < 26) begin
                    queue_req(FUNC_PUT, CH_NEWLINE, 11'($urandom));
                end
                else if (pick < 30) begin
                    queue_req(FUNC_PUT, CH_RETURN, 11'($urandom));
                end
                else if (pick < 36) begin
                    // control bytes other than newline/return, or the high half
                    do ch = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                                       : 8'($urandom_range(128, 255));
                    while (ch == CH_NEWLINE || ch == CH_RETURN);
                    queue_req(FUNC_PUT, ch, 11'($urandom));
                end
                else begin
                    queue_req(FUNC_PUT, 8'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT)),
                              11'($urandom));
                end
            end
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (console_results_due.size() != 0)
            report_error($sformatf("%0d results never arrived", console_results_due.size()));
        if (error_count == 0)
            $display("text_console_cursor_scroll_top verification clean");
        else
            $display("text_console_cursor_scroll_top verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/tccs_pkg.sv
hdl/tccs_ctrl.sv
hdl/tccs_dp.sv
hdl/text_console_cursor_scroll_top.sv
sim/tb_text_console_cursor_scroll_top.sv
